>>> rtl/core/htpd_pkg.sv
// Shared types and constants for the hex text packet deframer.
`timescale 1ns / 1ps
`default_nettype none

package htpd_pkg;

    // Result kinds carried on the output tuser
    localparam logic [1:0] KIND_DATA     = 2'd0;
    localparam logic [1:0] KIND_END      = 2'd1;
    localparam logic [1:0] KIND_OVERFLOW = 2'd2;

    localparam int unsigned KIND_W  = 2;
    localparam int unsigned CHAR_W  = 8;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned LEN_W   = 16;
    localparam int unsigned OUT_W   = BYTE_W + LEN_W;

    localparam logic [LEN_W-1:0] MAX_LEN_RESET = 16'd2048;

    // Character codes used by the classifier
    localparam logic [CHAR_W-1:0] CHAR_TAB     = 8'h09;
    localparam logic [CHAR_W-1:0] CHAR_CR      = 8'h0D;
    localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE    = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_F = 8'h46;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_F = 8'h66;

    // Classification of one character
    typedef struct packed {
        logic       blank;
        logic       hex;
        logic [3:0] digit;
    } char_class_t;

endpackage

`default_nettype wire

>>> rtl/core/hex_text_packet_deframer_core.sv
// Top level of the hex text packet deframer.
`timescale 1ns / 1ps
`default_nettype none

// Turns a stream of ASCII hex characters into data bytes, packet-end
// markers and overflow errors. One character is taken every clock cycle
// for as long as the result side keeps up; a character is held in an input
// register and its result is then loaded into the result register, from
// which it is offered on the result stream until taken. Characters that
// give no result still take their slot in the input register. The result
// register is refilled in the same cycle it is emptied, so no bubbles
// appear under continuous flow. The maximum packet length register is
// written over the cfg channel, which is always ready; write it only while
// no characters are in flight.
module hex_text_packet_deframer_core (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // Configuration: max_packet_len
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [htpd_pkg::LEN_W-1:0]    cfg_data,
    // Input stream
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [htpd_pkg::CHAR_W-1:0]   s_axis_tdata,   // [7:0] char_in
    // Result stream
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output logic [htpd_pkg::OUT_W-1:0]         m_axis_tdata,   // [7:0] data_byte,
                                                               // [23:8] packet_length
    output logic [htpd_pkg::KIND_W-1:0]        m_axis_tuser    // [1:0] kind
);

    // Input register
    logic                          in_valid_reg, in_valid_next;
    logic [htpd_pkg::CHAR_W-1:0]   in_char_reg;

    // Decoder state
    logic [3:0]                    high_nibble_reg, high_nibble_next;
    logic                          pending_reg, pending_next;
    logic [htpd_pkg::LEN_W-1:0]    count_reg, count_next;
    logic                          discard_reg, discard_next;
    logic [htpd_pkg::LEN_W-1:0]    max_len_reg;

    // Result register
    logic                          out_valid_reg, out_valid_next;
    logic [htpd_pkg::KIND_W-1:0]   out_kind_reg, out_kind_next;
    logic [htpd_pkg::BYTE_W-1:0]   out_byte_reg, out_byte_next;
    logic [htpd_pkg::LEN_W-1:0]    out_len_reg, out_len_next;

    logic                          advance;
    logic                          res_valid;
    htpd_pkg::char_class_t         cls;

    htpd_char_class u_class (
        .char_code (in_char_reg),
        .cls       (cls)
    );

    // Character in the input register is consumed when the result slot is free
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign cfg_ready     = 1'b1;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tdata  = {out_len_reg, out_byte_reg};

    // Decode step for the registered character
    always_comb
    begin
        high_nibble_next = high_nibble_reg;
        pending_next     = pending_reg;
        count_next       = count_reg;
        discard_next     = discard_reg;
        res_valid        = 1'b0;
        out_kind_next    = htpd_pkg::KIND_DATA;
        out_byte_next    = '0;
        out_len_next     = '0;

        if (advance)
        begin
            if (cls.blank)
            begin
                pending_next = 1'b0;
                discard_next = 1'b0;
                if (count_reg != '0)
                begin
                    res_valid     = 1'b1;
                    out_kind_next = htpd_pkg::KIND_END;
                    out_len_next  = count_reg;
                    count_next    = '0;
                end
            end
            else if (!discard_reg)
            begin
                if (!cls.hex)
                begin
                    pending_next = 1'b0;
                end
                else if (!pending_reg)
                begin
                    high_nibble_next = cls.digit;
                    pending_next     = 1'b1;
                end
                else
                begin
                    pending_next = 1'b0;
                    res_valid    = 1'b1;
                    if (count_reg >= max_len_reg)
                    begin
                        // Packet too long: report once, drop to next whitespace
                        count_next    = '0;
                        discard_next  = 1'b1;
                        out_kind_next = htpd_pkg::KIND_OVERFLOW;
                    end
                    else
                    begin
                        count_next    = count_reg + 1'b1;
                        out_kind_next = htpd_pkg::KIND_DATA;
                        out_byte_next = {high_nibble_reg, cls.digit};
                    end
                end
            end
        end
    end

    // Handshake bookkeeping for both registers
    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_axis_tready)
        begin
            in_valid_next = s_axis_tvalid;
        end

        out_valid_next = out_valid_reg;
        if (advance && res_valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            high_nibble_reg <= '0;
            pending_reg     <= 1'b0;
            count_reg       <= '0;
            discard_reg     <= 1'b0;
            max_len_reg     <= htpd_pkg::MAX_LEN_RESET;
        end
        else
        begin
            in_valid_reg    <= in_valid_next;
            out_valid_reg   <= out_valid_next;
            high_nibble_reg <= high_nibble_next;
            pending_reg     <= pending_next;
            count_reg       <= count_next;
            discard_reg     <= discard_next;
            if (cfg_valid && cfg_ready)
            begin
                max_len_reg <= cfg_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_char_reg <= s_axis_tdata;
        end
        if (advance && res_valid)
        begin
            out_kind_reg <= out_kind_next;
            out_byte_reg <= out_byte_next;
            out_len_reg  <= out_len_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/htpd_char_class.sv
// Character classifier: whitespace detect and hex digit decode.
`timescale 1ns / 1ps
`default_nettype none

module htpd_char_class (
    input  wire logic [htpd_pkg::CHAR_W-1:0] char_code,
    output htpd_pkg::char_class_t            cls
);

    logic is_dec;
    logic is_alpha;

    // Range checks; letters a-f and A-F share low nibbles 1..6
    always_comb
    begin
        is_dec   = (char_code >= htpd_pkg::CHAR_ZERO) && (char_code <= htpd_pkg::CHAR_NINE);
        is_alpha = ((char_code >= htpd_pkg::CHAR_LOWER_A) &&
                    (char_code <= htpd_pkg::CHAR_LOWER_F)) ||
                   ((char_code >= htpd_pkg::CHAR_UPPER_A) &&
                    (char_code <= htpd_pkg::CHAR_UPPER_F));

        cls.blank = (char_code == htpd_pkg::CHAR_SPACE) ||
                    ((char_code >= htpd_pkg::CHAR_TAB) && (char_code <= htpd_pkg::CHAR_CR));
        cls.hex   = is_dec || is_alpha;
        cls.digit = is_alpha ? (char_code[3:0] + 4'd9) : char_code[3:0];
    end

endmodule

`default_nettype wire

>>> rtl/core/htpd_checker.sv
// Port-level checks for the hex text packet deframer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module htpd_checker (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        m_axis_tvalid,
    input wire logic                        m_axis_tready,
    input wire logic [htpd_pkg::OUT_W-1:0]  m_axis_tdata,
    input wire logic [htpd_pkg::KIND_W-1:0] m_axis_tuser
);

    // A stalled result stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result transfer withdrawn while stalled");

    // Only the three defined kinds appear
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tuser == htpd_pkg::KIND_DATA) ||
                          (m_axis_tuser == htpd_pkg::KIND_END) ||
                          (m_axis_tuser == htpd_pkg::KIND_OVERFLOW))
        else $error("undefined result kind");

    // A packet end always carries a nonzero length and no data byte
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == htpd_pkg::KIND_END) |->
            (m_axis_tdata[23:8] != 16'd0) && (m_axis_tdata[7:0] == 8'd0))
        else $error("packet end with bad fields");

    // Data bytes carry no length
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == htpd_pkg::KIND_DATA) |->
            m_axis_tdata[23:8] == 16'd0)
        else $error("data byte with nonzero length");

    // Overflow carries empty payload
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == htpd_pkg::KIND_OVERFLOW) |->
            m_axis_tdata == '0)
        else $error("overflow with nonzero payload");

endmodule

bind hex_text_packet_deframer_core htpd_checker u_htpd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
